@@ rtl/iacc_pkg.sv @@
package iacc_pkg;

  typedef enum logic [3:0] {
    ACT_ADD  = 4'd0,
    ACT_SUB  = 4'd1,
    ACT_MUL  = 4'd2,
    ACT_DIV  = 4'd3,
    ACT_QUOT = 4'd4,
    ACT_REM  = 4'd5,
    ACT_MAX  = 4'd6,
    ACT_MIN  = 4'd7,
    ACT_AND  = 4'd8,
    ACT_OR   = 4'd9,
    ACT_XOR  = 4'd10
  } action_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_DIVZERO = 2'd1,
    STS_NOARG   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_iter;
    logic emit;
  } dp_stat_t;

endpackage

@@ rtl/iacc_ctrl.sv @@
module iacc_ctrl
  import iacc_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  localparam int CntW = $clog2(WIDTH);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = stat_i.need_iter ? ST_ITER : ST_WRITE;
        end
      end
      ST_ITER: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CntW'(WIDTH - 1)) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!(stat_i.emit && out_valid_q && !out_ready_i)) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
          if (stat_i.emit) begin
            out_valid_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/iacc_dp.sv @@
module iacc_dp
  import iacc_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_stat_t           stat_o,
  input  logic [3:0]         action_i,
  input  logic signed [31:0] operand_i,
  input  logic               first_i,
  input  logic               last_i,
  input  logic               no_args_i,
  output logic signed [31:0] value_o,
  output logic [1:0]         status_o
);

  logic [WIDTH-1:0] acc_q, acc_d;
  logic [3:0]       lact_q, lact_d;
  logic [1:0]       err_q, err_d;

  logic [WIDTH-1:0] v_q;
  logic [3:0]       act_q;
  logic             first_q, last_q, noargs_q;

  logic [WIDTH-1:0] rem_q, quo_q, dvs_q;
  logic [WIDTH-1:0] rem_d, quo_d;

  logic [31:0]      value_q;
  logic [1:0]       status_q;

  logic [WIDTH-1:0] v_in, acc_mag, comb, qs, rs, shifted;
  logic [WIDTH:0]   trial;
  logic             acc_neg, v_neg, divop_in, divop;

  assign v_in     = WIDTH'(operand_i);
  assign acc_neg  = acc_q[WIDTH-1];
  assign v_neg    = v_q[WIDTH-1];
  assign acc_mag  = acc_neg ? (~acc_q + 1'b1) : acc_q;
  assign divop_in = (lact_q == ACT_DIV) || (lact_q == ACT_QUOT) || (lact_q == ACT_REM);
  assign divop    = divop_in;

  assign stat_o.need_iter = !no_args_i && !first_i && (err_q == STS_OK) &&
                            ((lact_q == ACT_MUL) || (divop_in && (v_in != '0)));
  assign stat_o.emit      = noargs_q || last_q;

  // One restoring-division or shift-add multiply step per cycle.
  assign shifted = {rem_q[WIDTH-2:0], quo_q[WIDTH-1]};
  assign trial   = {1'b0, shifted} - {1'b0, dvs_q};

  always_comb begin
    if (lact_q == ACT_MUL) begin
      rem_d = {rem_q[WIDTH-2:0], 1'b0} + (quo_q[WIDTH-1] ? acc_q : '0);
      quo_d = {quo_q[WIDTH-2:0], 1'b0};
    end else if (!trial[WIDTH]) begin
      rem_d = trial[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], 1'b1};
    end else begin
      rem_d = shifted;
      quo_d = {quo_q[WIDTH-2:0], 1'b0};
    end
  end

  assign qs = (acc_neg != v_neg) ? (~quo_q + 1'b1) : quo_q;
  assign rs = acc_neg ? (~rem_q + 1'b1) : rem_q;

  always_comb begin
    unique case (action_e'(lact_q))
      ACT_ADD:  comb = acc_q + v_q;
      ACT_SUB:  comb = acc_q - v_q;
      ACT_MUL:  comb = rem_q;
      ACT_DIV:  comb = qs;
      ACT_QUOT: comb = qs;
      ACT_REM:  comb = rs;
      ACT_MAX:  comb = ($signed(acc_q) < $signed(v_q)) ? v_q : acc_q;
      ACT_MIN:  comb = ($signed(v_q) < $signed(acc_q)) ? v_q : acc_q;
      ACT_AND:  comb = acc_q & v_q;
      ACT_OR:   comb = acc_q | v_q;
      ACT_XOR:  comb = acc_q ^ v_q;
      default:  comb = acc_q;
    endcase
  end

  always_comb begin
    acc_d  = acc_q;
    lact_d = lact_q;
    err_d  = err_q;
    if (noargs_q) begin
      lact_d = act_q;
      acc_d  = '0;
      err_d  = STS_OK;
      if (act_q == ACT_MUL) begin
        acc_d = WIDTH'(1);
      end else if (act_q != ACT_ADD) begin
        err_d = STS_NOARG;
      end
    end else if (first_q) begin
      lact_d = act_q;
      err_d  = STS_OK;
      acc_d  = v_q;
      if (last_q) begin
        if (act_q == ACT_SUB) begin
          acc_d = ~v_q + 1'b1;
        end else if (act_q == ACT_DIV) begin
          if (v_q == '0) begin
            err_d = STS_DIVZERO;
          end else if (v_q != WIDTH'(1) && v_q != '1) begin
            acc_d = '0;
          end
        end
      end
    end else if (err_q == STS_OK) begin
      if (divop && v_q == '0) begin
        err_d = STS_DIVZERO;
      end else begin
        acc_d = comb;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      lact_q <= '0;
      err_q  <= STS_OK;
    end else if (cmd_i.commit) begin
      acc_q  <= acc_d;
      lact_q <= lact_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q      <= v_in;
      act_q    <= action_i;
      first_q  <= first_i;
      last_q   <= last_i;
      noargs_q <= no_args_i;
      rem_q    <= '0;
      quo_q    <= (lact_q == ACT_MUL) ? v_in : acc_mag;
      dvs_q    <= v_in[WIDTH-1] ? (~v_in + 1'b1) : v_in;
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.commit && stat_o.emit) begin
      value_q  <= (err_d != STS_OK) ? '0 : 32'(acc_d);
      status_q <= err_d;
    end
  end

  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

@@ rtl/integer_accumulate_alu.sv @@
// Accumulating integer ALU with an iterative multiply and divide unit.
// The input channel (in_valid_i/in_ready_o) carries one operand per transfer
// together with the action and the first, last and no_args flags. The first
// item of a run latches the action and loads the accumulator; later items
// fold into it. An item marked last or no_args produces one result on the
// output channel (out_valid_o/out_ready_i) as value_o and status_o.
// Multiply, divide, quotient and remainder items that combine into the
// accumulator commit only after the shared shift-and-add / restoring-divide
// unit has worked through all WIDTH bits, retiring one bit per cycle. All
// other items go from the load registers to the write state and commit there.
// A result is valid on the output from its commit edge on. One item is in
// flight at a time; in_ready_o is high whenever the block waits for an item,
// even while a result is held in the output register. If a new result is
// ready while the receiver stalls, the block holds that item until the
// output register is taken.
// Reset clears the accumulator, the latched action, the error code and the
// output valid flag; no result is pending after reset.
module integer_accumulate_alu
  import iacc_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         action_i,
  input  logic signed [31:0] operand_i,
  input  logic               first_i,
  input  logic               last_i,
  input  logic               no_args_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic [1:0]         status_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  iacc_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  iacc_dp #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .action_i (action_i),
    .operand_i(operand_i),
    .first_i  (first_i),
    .last_i   (last_i),
    .no_args_i(no_args_i),
    .value_o  (value_o),
    .status_o (status_o)
  );

endmodule
